// ===== design/heap_class_size_tally_macros.svh =====
// Assertion macros for the heap class size tally checker
`ifndef HEAP_CLASS_SIZE_TALLY_MACROS_SVH
`define HEAP_CLASS_SIZE_TALLY_MACROS_SVH

// same-cycle implication, disabled in reset
`define HCST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcst check failed");

// next-cycle implication, disabled in reset
`define HCST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcst check failed");

`endif

// ===== design/hcst_pkg.sv =====
// Shared types, constants and functions of the heap class size tally
`default_nettype none
package hcst_pkg;
  localparam int MAX_CLASSES_DEF = 4096;
  localparam int ID_W    = 20;
  localparam int LIM_W   = 13;
  localparam int COUNT_W = 40;
  localparam int SIZE_W  = 56;
  localparam int TAG_W   = 64;
  localparam int IN_W    = 192;
  localparam int OUT_W   = 216;

  localparam logic [1:0] OP_ROOT = 2'd0;
  localparam logic [1:0] OP_OBJ  = 2'd1;
  localparam logic [1:0] OP_MARK = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  typedef enum logic [1:0] {K_NONE, K_TALLY, K_MARK, K_READ} kind_t;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_MOD, S_OUT} state_t;

  typedef struct packed {
    kind_t                  kind;
    logic [ID_W-1:0]        idx;
    logic [COUNT_W-1:0]     size;
    logic                   flag;
    logic                   tag_write;
    logic                   anc;
    logic [2:0]             anc_mask;
    logic [2:0][ID_W-1:0]   anc_idx;
    logic [TAG_W-1:0]       tag_plain;
    logic [TAG_W-1:0]       tag_anc;
  } cmd_t;

  typedef struct packed {
    logic               mark;
    logic [SIZE_W-1:0]  charged;
    logic [SIZE_W-1:0]  own;
    logic [COUNT_W-1:0] count;
  } entry_t;

  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] a);
    return (&a) ? a : a + COUNT_W'(1);
  endfunction

  function automatic logic [SIZE_W-1:0] sat_add(logic [SIZE_W-1:0] a,
                                                 logic [COUNT_W-1:0] b);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + (SIZE_W+1)'(b);
    return s[SIZE_W] ? {SIZE_W{1'b1}} : s[SIZE_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== design/hcst_front.sv =====
// Front end: limit register, item decode and classification into commands
`default_nettype none
module hcst_front import hcst_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire  [LIM_W-1:0] cfg_data,
  input  wire  [1:0]       op,
  input  wire  [IN_W-1:0]  data,
  output cmd_t             cmd
);
  localparam logic [ID_W-1:0] MAXC = ID_W'(MAX_CLASSES);

  logic [LIM_W-1:0] class_limit;
  logic [ID_W-1:0]  lim, c, t, g, p, tp;
  logic [COUNT_W-1:0] size;
  logic has_tag, flag;
  logic [TAG_W-1:0] tag, rtag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_limit <= '0;
    end else if (cfg_valid) begin
      class_limit <= cfg_data;
    end
  end

  assign c       = data[19:0];
  assign size    = data[59:20];
  assign has_tag = data[60];
  assign tag     = data[124:61];
  assign rtag    = data[188:125];
  assign flag    = data[189];
  assign t       = rtag[59:40];
  assign g       = rtag[39:20];
  assign p       = rtag[19:0];
  assign lim     = (ID_W'(class_limit) > MAXC) ? MAXC : ID_W'(class_limit);
  assign tp      = (t != '0) ? c : '0;

  always_comb begin
    cmd            = '0;
    cmd.kind       = K_NONE;
    cmd.size       = size;
    cmd.flag       = flag;
    cmd.tag_plain  = {1'b1, 43'd0, c};
    cmd.tag_anc    = {1'b1, 3'd0, tp, p, c};
    cmd.anc_idx[0] = p - ID_W'(1);
    cmd.anc_idx[1] = g - ID_W'(1);
    cmd.anc_idx[2] = t - ID_W'(1);
    cmd.anc_mask[0] = (p != '0) && (p < lim) && (p != c);
    cmd.anc_mask[1] = (g != '0) && (g < lim) && (g != c) && (g != p);
    cmd.anc_mask[2] = (t != '0) && (t < lim) && (t != c) && (t != p) && (t != g);
    unique case (op)
      OP_MARK: begin
        if (c < MAXC) begin
          cmd.kind = K_MARK;
          cmd.idx  = c;
        end
      end
      OP_READ: begin
        if (c < MAXC) begin
          cmd.kind = K_READ;
          cmd.idx  = c;
        end
      end
      OP_ROOT, OP_OBJ: begin
        if (c != '0 && c <= lim && (!has_tag || tag == '0)) begin
          cmd.kind      = K_TALLY;
          cmd.idx       = c - ID_W'(1);
          cmd.tag_write = has_tag;
          cmd.anc       = has_tag && (op == OP_OBJ) && (rtag != '0);
        end
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== design/hcst_queue.sv =====
// Two-entry command queue between front and back
`default_nettype none
module hcst_queue import hcst_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  wire  rd_en,
  output logic rd_valid,
  output cmd_t rd_cmd
);
  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule
`default_nettype wire

// ===== design/hcst_back.sv =====
// Back end: class table, clearing pass, read-modify-write sequencer, result register
`default_nettype none
module hcst_back import hcst_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              q_valid,
  input  cmd_t             q_cmd,
  output logic             q_pop,
  output logic             clearing,
  output logic             m_tvalid,
  input  wire              m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tuser
);
  localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  entry_t mem [MAX_CLASSES];
  entry_t rdata, wr_data;
  logic [AW-1:0] wr_addr, addr, clr_cnt;
  logic rd_en, wr_en, out_load;

  state_t state, state_next;
  cmd_t   cur;
  logic   own_stage, use_anc, more;
  logic [2:0] mask, mask_next;
  logic [AW-1:0] addr_next;
  logic [COUNT_W-1:0] res_count;
  logic [SIZE_W-1:0]  res_own, res_charged;
  logic [TAG_W-1:0]   tag_out;

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // lowest pending ancestor first
  always_comb begin
    mask_next = mask;
    addr_next = addr;
    priority if (mask[0]) begin
      mask_next[0] = 1'b0;
      addr_next    = AW'(cur.anc_idx[0]);
    end else if (mask[1]) begin
      mask_next[1] = 1'b0;
      addr_next    = AW'(cur.anc_idx[1]);
    end else if (mask[2]) begin
      mask_next[2] = 1'b0;
      addr_next    = AW'(cur.anc_idx[2]);
    end
  end

  assign more = own_stage ? (cur.kind == K_TALLY && cur.anc && rdata.mark && mask != '0)
                          : (mask != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == AW'(MAX_CLASSES - 1)) state_next = S_IDLE;
      S_IDLE:  if (q_valid) state_next = (q_cmd.kind == K_NONE) ? S_OUT : S_READ;
      S_READ:  state_next = S_MOD;
      S_MOD:   state_next = more ? S_READ : S_OUT;
      S_OUT:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    clearing = (state == S_CLEAR);
    q_pop    = (state == S_IDLE) && q_valid;
    rd_en    = (state == S_READ);
    out_load = (state == S_OUT) && (!m_tvalid || m_tready);
    wr_en    = 1'b0;
    wr_addr  = addr;
    wr_data  = rdata;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
      end
      S_MOD: begin
        if (!own_stage) begin
          wr_en           = 1'b1;
          wr_data.charged = sat_add(rdata.charged, cur.size);
        end else if (cur.kind == K_MARK) begin
          wr_en        = 1'b1;
          wr_data.mark = cur.flag;
        end else if (cur.kind == K_TALLY) begin
          wr_en         = 1'b1;
          wr_data.count = sat_inc(rdata.count);
          wr_data.own   = sat_add(rdata.own, cur.size);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (out_load)         m_tvalid <= 1'b1;
      else if (m_tready)    m_tvalid <= 1'b0;
    end
  end

  assign tag_out = use_anc ? cur.tag_anc : cur.tag_plain;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur       <= q_cmd;
      addr      <= AW'(q_cmd.idx);
      mask      <= q_cmd.anc_mask;
      own_stage <= 1'b1;
      use_anc   <= 1'b0;
      res_count <= '0;
      res_own   <= '0;
      res_charged <= '0;
    end
    if (state == S_MOD) begin
      if (own_stage) begin
        use_anc <= cur.anc && rdata.mark;
        if (cur.kind == K_READ) begin
          res_count   <= rdata.count;
          res_own     <= rdata.own;
          res_charged <= rdata.charged;
        end
      end
      if (more) begin
        own_stage <= 1'b0;
        mask      <= mask_next;
        addr      <= addr_next;
      end
    end
    if (out_load) begin
      m_tuser <= (cur.kind == K_TALLY) && cur.tag_write;
      m_tdata <= {res_charged, res_own, res_count,
                  ((cur.kind == K_TALLY) && cur.tag_write) ? tag_out : '0};
    end
  end
endmodule
`default_nettype wire

// ===== design/heap_class_size_tally.sv =====
// Top level of the heap class size tally
// Sequencing: ignored items go straight to the result register; reads, marks and tallies
// each pass through the class table read and modify steps, own class plus up to three ancestors for tallies.
// The back end handles one item at a time, one table entry at a time; the queue holds further items meanwhile.
// Reset: synchronous; a clearing pass over all MAX_CLASSES entries follows, no items taken meanwhile.
`default_nettype none
module heap_class_size_tally import hcst_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire  [LIM_W-1:0] cfg_data,      // class_limit
  input  wire              s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire  [IN_W-1:0]  s_axis_tdata,  // cls_id, obj_size, has_tag, tag_value,
                                          // ref_tag, charge_flag, zero pad
  input  wire  [1:0]       s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  wire              m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // new_tag, entry_count, entry_self_size,
                                          // entry_child_size
  output logic             m_axis_tuser   // tag_write
);
  cmd_t cmd, q_cmd;
  logic q_full, q_valid, q_pop, clearing, q_wr;

  assign s_axis_tready = !q_full && !clearing;
  assign q_wr          = s_axis_tvalid && s_axis_tready;

  hcst_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data,
    .op(s_axis_tuser), .data(s_axis_tdata), .cmd
  );

  hcst_queue u_queue (
    .clk, .rst, .wr_en(q_wr), .wr_cmd(cmd), .full(q_full),
    .rd_en(q_pop), .rd_valid(q_valid), .rd_cmd(q_cmd)
  );

  hcst_back #(.MAX_CLASSES(MAX_CLASSES)) u_back (
    .clk, .rst, .q_valid, .q_cmd, .q_pop, .clearing,
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser)
  );
endmodule
`default_nettype wire

// ===== design/hcst_checker.sv =====
// Port-level checker for the heap class size tally, bound to the top level
`default_nettype none
`include "heap_class_size_tally_macros.svh"
module hcst_checker import hcst_pkg::*; (
  input wire             clk,
  input wire             rst,
  input wire             m_axis_tvalid,
  input wire             m_axis_tready,
  input wire [OUT_W-1:0] m_axis_tdata,
  input wire             m_axis_tuser
);
  `HCST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `HCST_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `HCST_ASSERT_NOW(a_no_write_tag, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[63:0] == '0)
  `HCST_ASSERT_NOW(a_write_fields, m_axis_tvalid && m_axis_tuser, m_axis_tdata[63] && m_axis_tdata[62:60] == '0 && m_axis_tdata[OUT_W-1:64] == '0)
endmodule

bind heap_class_size_tally hcst_checker u_checker (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
